// File: src/brl_pkg.sv
// Shared types and constants for the Bresenham line rasterizer.
// Depends on nothing; the RTL files refer to it by scoped names, the bench imports it.
`default_nettype none
package brl_pkg;

  localparam int COORD_BITS = 8;
  localparam int ERR_BITS   = COORD_BITS + 3;

  typedef logic [COORD_BITS-1:0]      coord_t;
  typedef logic signed [ERR_BITS-1:0] err_t;

  typedef enum logic {
    KIND_LOAD = 1'b0,
    KIND_STEP = 1'b1
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  start_x;
    logic [7:0]  start_y;
    logic [7:0]  end_x;
    logic [7:0]  end_y;
    logic [15:0] line_color;
  } req_word_t;

  typedef struct packed {
    logic        pixel_valid;
    logic [7:0]  pixel_x;
    logic [7:0]  pixel_y;
    logic [15:0] pixel_color;
    logic        line_done;
  } pix_word_t;

endpackage
`default_nettype wire

// File: src/brl_in_stage.sv
// Input register of the rasterizer: captures one request word and holds it
// until the core consumes it. Depends on brl_pkg.
`default_nettype none
module brl_in_stage (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              req_valid,
  output logic                   req_ready,
  input  wire brl_pkg::req_word_t req,
  input  wire logic              consume,
  output logic                   held_valid,
  output brl_pkg::req_word_t     held
);

  assign req_ready = !held_valid || consume;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (req_ready) begin
      held_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_ready && req_valid) begin
      held <= req;
    end
  end

endmodule
`default_nettype wire

// File: src/brl_core.sv
// Line state and per-word update: octant setup on load, one pixel and
// error update on step while a line is busy. Depends on brl_pkg.
`default_nettype none
module brl_core (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               advance,
  input  wire brl_pkg::req_word_t item,
  output brl_pkg::pix_word_t      result
);

  brl_pkg::coord_t major_pos, major_pos_next;
  brl_pkg::coord_t minor_pos, minor_pos_next;
  brl_pkg::coord_t major_end, major_end_next;
  brl_pkg::coord_t minor_delta, minor_delta_next;
  brl_pkg::coord_t major_delta, major_delta_next;
  brl_pkg::err_t   error_term, error_term_next;
  logic            minor_dir_negative, minor_dir_negative_next;
  logic            steep_mode, steep_mode_next;
  logic [15:0]     held_color, held_color_next;
  logic            busy, busy_next;

  brl_pkg::coord_t x0, y0, x1, y1;
  brl_pkg::coord_t adx, ady;
  brl_pkg::coord_t p0, q0, p1, q1;
  brl_pkg::coord_t a0, b0, a1, b1;
  brl_pkg::coord_t dmin, dmaj;
  logic            steep_ld;
  brl_pkg::err_t   err_load, inc_diag, inc_flat;
  brl_pkg::coord_t major_step;

  always_comb begin
    x0 = item.start_x[brl_pkg::COORD_BITS-1:0];
    y0 = item.start_y[brl_pkg::COORD_BITS-1:0];
    x1 = item.end_x[brl_pkg::COORD_BITS-1:0];
    y1 = item.end_y[brl_pkg::COORD_BITS-1:0];
    adx = (x1 >= x0) ? x1 - x0 : x0 - x1;
    ady = (y1 >= y0) ? y1 - y0 : y0 - y1;
    steep_ld = !(ady < adx);
    p0 = steep_ld ? y0 : x0;
    q0 = steep_ld ? x0 : y0;
    p1 = steep_ld ? y1 : x1;
    q1 = steep_ld ? x1 : y1;
    a0 = (p0 > p1) ? p1 : p0;
    b0 = (p0 > p1) ? q1 : q0;
    a1 = (p0 > p1) ? p0 : p1;
    b1 = (p0 > p1) ? q0 : q1;
    dmin = (b1 >= b0) ? b1 - b0 : b0 - b1;
    dmaj = a1 - a0;
    err_load = brl_pkg::err_t'({2'b00, dmin, 1'b0}) - brl_pkg::err_t'({3'b000, dmaj});
  end

  always_comb begin
    inc_diag   = brl_pkg::err_t'({2'b00, minor_delta, 1'b0})
               - brl_pkg::err_t'({2'b00, major_delta, 1'b0});
    inc_flat   = brl_pkg::err_t'({2'b00, minor_delta, 1'b0});
    major_step = major_pos + brl_pkg::coord_t'(1);
  end

  always_comb begin
    major_pos_next          = major_pos;
    minor_pos_next          = minor_pos;
    major_end_next          = major_end;
    minor_delta_next        = minor_delta;
    major_delta_next        = major_delta;
    error_term_next         = error_term;
    minor_dir_negative_next = minor_dir_negative;
    steep_mode_next         = steep_mode;
    held_color_next         = held_color;
    busy_next               = busy;
    result                  = '0;

    unique case (item.kind)
      brl_pkg::KIND_LOAD: begin
        held_color_next         = item.line_color;
        steep_mode_next         = steep_ld;
        minor_dir_negative_next = b1 < b0;
        major_pos_next          = a0;
        minor_pos_next          = b0;
        major_end_next          = a1;
        major_delta_next        = dmaj;
        minor_delta_next        = dmin;
        error_term_next         = err_load;
        busy_next               = a0 != a1;
      end
      brl_pkg::KIND_STEP: begin
        if (busy) begin
          result.pixel_valid = 1'b1;
          result.pixel_x     = 8'(steep_mode ? minor_pos : major_pos);
          result.pixel_y     = 8'(steep_mode ? major_pos : minor_pos);
          result.pixel_color = held_color;
          if (error_term > 0) begin
            minor_pos_next  = minor_dir_negative ? minor_pos - brl_pkg::coord_t'(1)
                                                 : minor_pos + brl_pkg::coord_t'(1);
            error_term_next = error_term + inc_diag;
          end else begin
            error_term_next = error_term + inc_flat;
          end
          major_pos_next = major_step;
          busy_next      = major_step != major_end;
        end
      end
      default: begin
      end
    endcase

    result.line_done = !busy_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      major_pos          <= '0;
      minor_pos          <= '0;
      major_end          <= '0;
      minor_delta        <= '0;
      major_delta        <= '0;
      error_term         <= '0;
      minor_dir_negative <= 1'b0;
      steep_mode         <= 1'b0;
      held_color         <= '0;
      busy               <= 1'b0;
    end else if (advance) begin
      major_pos          <= major_pos_next;
      minor_pos          <= minor_pos_next;
      major_end          <= major_end_next;
      minor_delta        <= minor_delta_next;
      major_delta        <= major_delta_next;
      error_term         <= error_term_next;
      minor_dir_negative <= minor_dir_negative_next;
      steep_mode         <= steep_mode_next;
      held_color         <= held_color_next;
      busy               <= busy_next;
    end
  end

endmodule
`default_nettype wire

// File: src/bresenham_line_rasterizer_unit.sv
// Top level of the Bresenham line rasterizer: input register, line core and
// result register. Depends on brl_pkg, brl_in_stage and brl_core.
//
//   channel   handshake               word         direction
//   req       req_valid / req_ready   req_word_t   in   load or step
//   pix       pix_valid / pix_ready   pix_word_t   out  one result per request
//
// Every request yields exactly one result, which goes through the result register.
// One request per cycle is sustained while pix_ready is high; the core updates
// the line state in the same cycle a word moves from input to result register.
// Synchronous reset clears the line state (no line loaded) and both valid flags.
// A stalled result holds; the input register still takes one more word.
`default_nettype none
module bresenham_line_rasterizer_unit (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               req_valid,
  output logic                    req_ready,
  input  wire brl_pkg::req_word_t req,
  output logic                    pix_valid,
  input  wire logic               pix_ready,
  output brl_pkg::pix_word_t      pix
);

  logic               held_valid;
  brl_pkg::req_word_t held;
  brl_pkg::pix_word_t result;
  logic               advance;

  assign advance = held_valid && (!pix_valid || pix_ready);

  brl_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .req        (req),
    .consume    (advance),
    .held_valid (held_valid),
    .held       (held)
  );

  brl_core u_core (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (held),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pix_valid <= 1'b0;
    end else if (advance) begin
      pix_valid <= 1'b1;
    end else if (pix_ready) begin
      pix_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      pix <= result;
    end
  end

endmodule
`default_nettype wire

// File: tb/sv/tb_bresenham_line_rasterizer_unit.sv
// Self-checking bench for bresenham_line_rasterizer_unit: directed and random line traffic
// with random idling on both channels. Every result is checked against a built-in line model.
// Depends on brl_pkg and the rasterizer RTL.
module tb_bresenham_line_rasterizer_unit;
  import brl_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      req_valid = 1'b0;
  logic      req_ready;
  req_word_t req       = '0;
  logic      pix_valid;
  logic      pix_ready = 1'b0;
  pix_word_t pix;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int mismatches    = 0;
  int cycles        = 0;

  pix_word_t expected_pixels[$];

  coord_t      ln_major       = '0;
  coord_t      ln_minor       = '0;
  coord_t      ln_major_end   = '0;
  int          ln_minor_delta = 0;
  int          ln_major_delta = 0;
  int          ln_err         = 0;
  logic        ln_minor_neg   = 1'b0;
  logic        ln_steep       = 1'b0;
  logic [15:0] ln_color       = '0;
  logic        ln_busy        = 1'b0;

  bresenham_line_rasterizer_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .pix_valid (pix_valid),
    .pix_ready (pix_ready),
    .pix       (pix)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(negedge clk) begin
    pix_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  function automatic pix_word_t rasterise(input req_word_t w);
    pix_word_t p;
    int        adx;
    int        ady;
    int        dmin;
    coord_t    a0;
    coord_t    b0;
    coord_t    a1;
    coord_t    b1;
    coord_t    t;
    p = '0;
    if (w.kind == KIND_LOAD) begin
      ln_color = w.line_color;
      adx = int'(w.end_x) - int'(w.start_x);
      ady = int'(w.end_y) - int'(w.start_y);
      if (adx < 0) adx = -adx;
      if (ady < 0) ady = -ady;
      ln_steep = !(ady < adx);
      if (!ln_steep) begin
        a0 = w.start_x; b0 = w.start_y; a1 = w.end_x; b1 = w.end_y;
      end else begin
        a0 = w.start_y; b0 = w.start_x; a1 = w.end_y; b1 = w.end_x;
      end
      if (a0 > a1) begin
        t = a0; a0 = a1; a1 = t;
        t = b0; b0 = b1; b1 = t;
      end
      dmin = int'(b1) - int'(b0);
      ln_minor_neg = (dmin < 0);
      if (dmin < 0) dmin = -dmin;
      ln_major       = a0;
      ln_minor       = b0;
      ln_major_end   = a1;
      ln_major_delta = int'(a1) - int'(a0);
      ln_minor_delta = dmin;
      ln_err         = 2 * ln_minor_delta - ln_major_delta;
      ln_busy        = (a0 != a1);
    end else if (ln_busy) begin
      p.pixel_valid = 1'b1;
      p.pixel_x     = ln_steep ? ln_minor : ln_major;
      p.pixel_y     = ln_steep ? ln_major : ln_minor;
      p.pixel_color = ln_color;
      if (ln_err > 0) begin
        ln_minor = ln_minor_neg ? ln_minor - 1'b1 : ln_minor + 1'b1;
        ln_err   = ln_err + 2 * (ln_minor_delta - ln_major_delta);
      end else begin
        ln_err = ln_err + 2 * ln_minor_delta;
      end
      ln_major = ln_major + 1'b1;
      if (ln_major == ln_major_end) ln_busy = 1'b0;
    end
    p.line_done = !ln_busy;
    return p;
  endfunction

  task automatic report_mismatch(input string what, input logic [33:0] got,
                                 input logic [33:0] want);
    if (mismatches < 100)
      $display("%0t mismatch %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    pix_word_t want;
    if (!rst && pix_valid && pix_ready) begin
      if (expected_pixels.size() == 0) begin
        report_mismatch("unexpected word", pix, '0);
      end else begin
        want = expected_pixels.pop_front();
        if (pix.pixel_valid !== want.pixel_valid)
          report_mismatch("pixel_valid", 34'(pix.pixel_valid), 34'(want.pixel_valid));
        if (pix.pixel_x !== want.pixel_x)
          report_mismatch("pixel_x", 34'(pix.pixel_x), 34'(want.pixel_x));
        if (pix.pixel_y !== want.pixel_y)
          report_mismatch("pixel_y", 34'(pix.pixel_y), 34'(want.pixel_y));
        if (pix.pixel_color !== want.pixel_color)
          report_mismatch("pixel_color", 34'(pix.pixel_color), 34'(want.pixel_color));
        if (pix.line_done !== want.line_done)
          report_mismatch("line_done", 34'(pix.line_done), 34'(want.line_done));
      end
    end
  end

  task automatic send_req(input req_word_t w);
    @(negedge clk);
    req       <= w;
    req_valid <= 1'b1;
    do @(posedge clk); while (!req_ready);
    expected_pixels.push_back(rasterise(w));
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      req_valid <= 1'b0;
    end
  endtask

  function automatic req_word_t rand_word();
    logic [48:0] bits_v;
    bits_v = 49'({$urandom, $urandom});
    return bits_v;
  endfunction

  task automatic send_step();
    req_word_t w;
    w      = rand_word();
    w.kind = KIND_STEP;
    send_req(w);
  endtask

  task automatic send_line(input logic [7:0] sx, input logic [7:0] sy, input logic [7:0] ex,
                           input logic [7:0] ey, input logic [15:0] color, input int steps);
    req_word_t w;
    w            = '0;
    w.kind       = KIND_LOAD;
    w.start_x    = sx;
    w.start_y    = sy;
    w.end_x      = ex;
    w.end_y      = ey;
    w.line_color = color;
    send_req(w);
    repeat (steps) send_step();
  endtask

  function automatic logic [7:0] nudge(input logic [7:0] c, input int span);
    int v;
    v = int'(c) + int'($urandom_range(2 * span)) - span;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v[7:0];
  endfunction

  task automatic test_step_when_idle();
    send_step();
    send_step();
  endtask

  task automatic test_zero_length();
    send_line(8'd255, 8'd255, 8'd255, 8'd255, 16'hffff, 1);
    send_line(8'd0, 8'd0, 8'd0, 8'd0, 16'h0000, 0);
  endtask

  task automatic test_octants();
    send_line(8'd128, 8'd128, 8'd130, 8'd129, 16'h1234, 2);
    send_line(8'd128, 8'd128, 8'd129, 8'd130, 16'h2345, 2);
    send_line(8'd128, 8'd128, 8'd126, 8'd129, 16'h3456, 2);
    send_line(8'd128, 8'd128, 8'd127, 8'd130, 16'h4567, 2);
    send_line(8'd128, 8'd128, 8'd130, 8'd127, 16'h5678, 2);
    send_line(8'd128, 8'd128, 8'd129, 8'd126, 16'h6789, 2);
    send_line(8'd128, 8'd128, 8'd126, 8'd127, 16'h789a, 2);
    send_line(8'd128, 8'd128, 8'd127, 8'd126, 16'h89ab, 2);
  endtask

  task automatic test_extremes_and_reload();
    send_line(8'd0, 8'd255, 8'd255, 8'd0, 16'h0000, 2);
    send_line(8'd255, 8'd0, 8'd0, 8'd0, 16'hffff, 1);
    send_line(8'd253, 8'd7, 8'd255, 8'd7, 16'ha5a5, 3);
    send_line(8'd2, 8'd1, 8'd0, 8'd0, 16'h5a5a, 3);
  endtask

  task automatic test_random_traffic(input int n);
    int          sent;
    int          span;
    int          len;
    int          dx;
    int          dy;
    int          steps;
    logic [7:0]  sx;
    logic [7:0]  sy;
    logic [7:0]  ex;
    logic [7:0]  ey;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(9) == 0) begin
        send_req(rand_word());
        sent++;
      end else begin
        sx = 8'($urandom_range(255));
        sy = 8'($urandom_range(255));
        if ($urandom_range(39) == 0) begin
          ex = 8'($urandom_range(255));
          ey = 8'($urandom_range(255));
        end else begin
          span = $urandom_range(12);
          ex   = nudge(sx, span);
          ey   = nudge(sy, span);
        end
        dx  = int'(ex) - int'(sx);
        dy  = int'(ey) - int'(sy);
        if (dx < 0) dx = -dx;
        if (dy < 0) dy = -dy;
        len = (dx > dy) ? dx : dy;
        if ($urandom_range(9) == 0 || len > 40 && $urandom_range(1) == 0)
          steps = $urandom_range(len);
        else
          steps = len + $urandom_range(2);
        send_line(sx, sy, ex, ey, 16'($urandom), steps);
        sent += steps + 1;
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_idle_pct = 13;
    recv_idle_pct = 83;
    test_step_when_idle();
    test_zero_length();
    test_octants();
    test_extremes_and_reload();
    test_random_traffic(500);

    send_idle_pct = 83;
    recv_idle_pct = 13;
    test_random_traffic(500);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(500);

    @(negedge clk);
    req_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
